### design/i2dt_pkg.sv
// Shared types and constants for the integer to decimal text converter.
package i2dt_pkg;

    // Default width of the signed input value
    localparam int VALUE_WIDTH_DEF = 64;

    // Decimal digit store: enough BCD digits for any magnitude up to 2^63
    localparam int MAX_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int POS_W      = $clog2(MAX_DIGITS);

    // Result field widths
    localparam int CHAR_W   = 6;
    localparam int LENGTH_W = 5;

    // ASCII codes, truncated to the character field
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_DIGITS
    } i2dt_state_t;

endpackage

### design/integer_to_decimal_text.sv
// Top level: signed integer to decimal ASCII text, one character per beat.
//
//  channel   | direction | ports                                  | beat carries
//  ----------+-----------+----------------------------------------+-------------------------
//  s_        | in        | s_valid, s_ready, s_value[63:0]        | one signed value
//  m_        | out       | m_valid, m_ready, m_character, m_last, | one ASCII character
//            |           | m_length                               |
//
// A value passes through the BCD converter (ST_CONV), a scan for the leading digit
// (ST_SCAN), then one character per cycle while m_ready does not stall the output
// (ST_SIGN, ST_DIGITS). The block returns to idle before the next value is taken,
// so it cannot accept a new value until its last character is in the output register.
// s_ready is high only while idle.
// A stalled m_ready holds the current character in the output register.
// aresetn is synchronous, active low, and returns the block to idle.
module integer_to_decimal_text
    import i2dt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [63:0]         s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHAR_W-1:0]   m_character,
    output logic                m_last,
    output logic [LENGTH_W-1:0] m_length
);

    localparam int PAD_W  = ((VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
    localparam int STEPS  = PAD_W / DIGIT_W;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    i2dt_state_t         state_reg, state_next;
    logic [PAD_W-1:0]    mag_reg, mag_next;
    bcd_t                bcd_reg, bcd_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [LENGTH_W-1:0] len_reg, len_next;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_character_reg, m_character_next;
    logic                m_last_reg, m_last_next;
    logic [LENGTH_W-1:0] m_length_reg, m_length_next;

    logic [VALUE_WIDTH-1:0] in_bits;
    logic [VALUE_WIDTH-1:0] in_mag;
    bcd_t                   bcd_step;
    logic [POS_W-1:0]       top_idx;
    logic                   out_free;

    // Take the value at its configured width and form the unsigned magnitude
    assign in_bits = s_value[VALUE_WIDTH-1:0];
    assign in_mag  = in_bits[VALUE_WIDTH-1] ? VALUE_WIDTH'(~in_bits + 1'b1) : in_bits;

    // Shared BCD step unit
    i2dt_dabble u_dabble (
        .bcd_in  (bcd_reg),
        .nibble  (mag_reg[PAD_W-1 -: DIGIT_W]),
        .bcd_out (bcd_step)
    );

    // Locate the most significant nonzero digit; zero keeps index 0
    always_comb begin
        top_idx = '0;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (bcd_reg[d] != '0) begin
                top_idx = POS_W'(d);
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer: next state and datapath controls
    always_comb begin
        state_next       = state_reg;
        mag_next         = mag_reg;
        bcd_next         = bcd_reg;
        cnt_next         = cnt_reg;
        neg_next         = neg_reg;
        pos_next         = pos_reg;
        len_next         = len_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_character_next = m_character_reg;
        m_last_next      = m_last_reg;
        m_length_next    = m_length_reg;
        s_ready          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mag_next   = PAD_W'(in_mag);
                    neg_next   = in_bits[VALUE_WIDTH-1];
                    bcd_next   = '0;
                    cnt_next   = STEP_W'(STEPS - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                // Fold four magnitude bits per cycle into the digit store
                bcd_next = bcd_step;
                mag_next = mag_reg << DIGIT_W;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                pos_next   = top_idx;
                len_next   = LENGTH_W'(top_idx) + LENGTH_W'(1) + LENGTH_W'(neg_reg);
                state_next = neg_reg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_character_next = CHAR_MINUS;
                    m_last_next      = 1'b0;
                    m_length_next    = '0;
                    state_next       = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                // Emit digits from the leading one down to the units digit
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_character_next = CHAR_ZERO + CHAR_W'(bcd_reg[pos_reg]);
                    m_last_next      = (pos_reg == '0);
                    m_length_next    = (pos_reg == '0) ? len_reg : '0;
                    pos_next         = pos_reg - 1'b1;
                    if (pos_reg == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath and output payload registers
    always_ff @(posedge aclk) begin
        mag_reg         <= mag_next;
        bcd_reg         <= bcd_next;
        cnt_reg         <= cnt_next;
        neg_reg         <= neg_next;
        pos_reg         <= pos_next;
        len_reg         <= len_next;
        m_character_reg <= m_character_next;
        m_last_reg      <= m_last_next;
        m_length_reg    <= m_length_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;
    assign m_length    = m_length_reg;

endmodule

### design/i2dt_dabble.sv
// Shift-and-add-3 BCD step unit: folds four binary bits into the digit store.
module i2dt_dabble
    import i2dt_pkg::*;
(
    input  bcd_t               bcd_in,
    input  logic [DIGIT_W-1:0] nibble,
    output bcd_t               bcd_out
);

    // Run four dependent single-bit steps, most significant bit first
    always_comb begin
        bcd_t                          work;
        logic [MAX_DIGITS*DIGIT_W-1:0] flat;
        work = bcd_in;
        for (int b = DIGIT_W - 1; b >= 0; b--) begin
            // Correct every digit that would overflow on doubling
            for (int d = 0; d < MAX_DIGITS; d++) begin
                if (work[d] >= DIGIT_W'(5)) begin
                    work[d] = work[d] + DIGIT_W'(3);
                end
            end
            // Double the store and shift in the next binary bit
            flat = work;
            flat = {flat[MAX_DIGITS*DIGIT_W-2:0], nibble[b]};
            work = flat;
        end
        bcd_out = work;
    end

endmodule
